>>> src/sclc_pkg.sv
// Shared types and constants for the staged consumption limit controller.
`timescale 1ns / 1ps

package sclc_pkg;

   localparam int CFG_W                = 32;
   localparam int CNT_W                = 32;
   localparam int FLOW_W               = 16;
   localparam int TOTAL_W              = 32;
   localparam int VOLUME_WIDTH_DEFAULT = 32;
   localparam int NUM_DETECTORS        = 6;
   localparam int SLOT_W               = $clog2(NUM_DETECTORS);
   localparam int FLAGS_W              = 4;
   localparam int CSR_INDEX_W          = 3;

   localparam logic [CFG_W-1:0] FIRST_THRESHOLD_RESET  = 32'd10000;
   localparam logic [CFG_W-1:0] SECOND_THRESHOLD_RESET = 32'd20000;
   localparam logic [CFG_W-1:0] THIRD_THRESHOLD_RESET  = 32'd30000;
   localparam logic [CFG_W-1:0] LIMIT_RESET            = 32'd40000;
   localparam logic [CFG_W-1:0] DETECT_INTERVAL_RESET  = 32'd100;
   localparam logic [CFG_W-1:0] ALARM_LENGTH_RESET     = 32'd5000;

   // used-level flags, thermometer coded
   localparam logic [FLAGS_W-1:0] FLAGS_NONE  = 4'b0000;
   localparam logic [FLAGS_W-1:0] FLAGS_LVL1  = 4'b0001;
   localparam logic [FLAGS_W-1:0] FLAGS_LVL2  = 4'b0011;
   localparam logic [FLAGS_W-1:0] FLAGS_LVL3  = 4'b0111;
   localparam logic [FLAGS_W-1:0] FLAGS_LIMIT = 4'b1111;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_OPEN  = 3'd1,
      MODE_AL1   = 3'd2,
      MODE_AL2   = 3'd3,
      MODE_AL3   = 3'd4,
      MODE_LIMIT = 3'd5,
      MODE_DONE  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_BUTTON  = 3'd1,
      EV_T1      = 3'd2,
      EV_T2      = 3'd3,
      EV_T3      = 3'd4,
      EV_LIMIT   = 3'd5,
      EV_TIMEOUT = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      BUZZ_OFF  = 3'd0,
      BUZZ_LVL1 = 3'd1,
      BUZZ_LVL2 = 3'd2,
      BUZZ_LVL3 = 3'd3,
      BUZZ_LVL4 = 3'd4
   } buzzer_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_THRESHOLD  = 3'd0,
      CSR_SECOND_THRESHOLD = 3'd1,
      CSR_THIRD_THRESHOLD  = 3'd2,
      CSR_LIMIT            = 3'd3,
      CSR_DETECT_INTERVAL  = 3'd4,
      CSR_ALARM_LENGTH     = 3'd5
   } csr_index_type;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_BUTTON  = 3'd0,
      SLOT_T1      = 3'd1,
      SLOT_T2      = 3'd2,
      SLOT_T3      = 3'd3,
      SLOT_LIMIT   = 3'd4,
      SLOT_TIMEOUT = 3'd5
   } slot_type;

endpackage

>>> src/staged_consumption_limit_controller.sv
// Top level: tick-driven water consumption limit controller.
//
//  channel  ports                                  dir  beat
//  -------  -------------------------------------  ---  ---------------------------------
//  req      req_valid/req_ready + button, flow      in   one millisecond tick
//  rsp      rsp_valid/rsp_ready + state ... total   out  one result per tick
//  csr      csr_wr_en, csr_index, csr_wdata         in   one register write, no wait
//
//  Beats: one tick beat per clock while the response register is empty or being drained;
//    the whole tick (saturating add, at most one detector attempt, state update) settles
//    combinationally into the state registers, which double as the response register.
//  Latency: the response for a tick is valid the cycle after its req beat.
//  Stalls: req_ready is high while the response register is empty or being drained,
//    so a new tick is taken in the same cycle the previous result leaves.
//  Reset: synchronous, active high; registers return to their default values,
//    state goes idle, valve closed, buzzer silent, total zero.
`timescale 1ns / 1ps

module staged_consumption_limit_controller
   import sclc_pkg::*;
#(
   parameter int VOLUME_WIDTH = VOLUME_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // tick input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_button_pushed,
   input  logic [FLOW_W-1:0]      req_flow_increment_ml,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_ctrl_state,
   output logic                   rsp_valve_open,
   output logic [2:0]             rsp_buzzer_level,
   output logic [2:0]             rsp_event_code,
   output logic [TOTAL_W-1:0]     rsp_total_volume_ml,
   // register writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // compare width wide enough for both the total and the 32-bit registers
   localparam int CMP_W = (VOLUME_WIDTH > CFG_W) ? VOLUME_WIDTH : CFG_W;

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] thr1_ff, thr2_ff, thr3_ff, limit_ff, interval_ff, alarm_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr1_ff      <= FIRST_THRESHOLD_RESET;
         thr2_ff      <= SECOND_THRESHOLD_RESET;
         thr3_ff      <= THIRD_THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
         interval_ff  <= DETECT_INTERVAL_RESET;
         alarm_len_ff <= ALARM_LENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_THRESHOLD:  thr1_ff      <= csr_wdata;
            CSR_SECOND_THRESHOLD: thr2_ff      <= csr_wdata;
            CSR_THIRD_THRESHOLD:  thr3_ff      <= csr_wdata;
            CSR_LIMIT:            limit_ff     <= csr_wdata;
            CSR_DETECT_INTERVAL:  interval_ff  <= csr_wdata;
            CSR_ALARM_LENGTH:     alarm_len_ff <= csr_wdata;
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // ---------------- controller state (doubles as response register) ----------------
   mode_type                mode_ff,      mode_in;
   logic [VOLUME_WIDTH-1:0] volume_ff,    volume_in;
   logic [FLAGS_W-1:0]      flags_ff,     flags_in;
   slot_type                slot_ff,      slot_in;
   logic [CNT_W-1:0]        det_cnt_ff,   det_cnt_in;
   logic [CNT_W-1:0]        alm_cnt_ff,   alm_cnt_in;
   logic                    valve_ff,     valve_in;
   buzzer_type              buzzer_ff,    buzzer_in;
   event_type               event_ff,     event_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    tick_accept;
   logic [VOLUME_WIDTH:0]   vol_sum;
   logic [VOLUME_WIDTH-1:0] vol_added;
   logic [CMP_W-1:0]        vol_cmp;
   logic [CMP_W-1:0]        thr1_cmp, thr2_cmp, thr3_cmp, limit_cmp;
   logic [CNT_W-1:0]        det_cnt_inc, alm_cnt_inc;
   logic                    attempt;
   event_type               det_event;
   logic [FLAGS_W-1:0]      det_flags;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign tick_accept = req_valid && req_ready;

   // saturating accumulate and counter increments
   assign vol_sum     = {1'b0, volume_ff} + (VOLUME_WIDTH+1)'(req_flow_increment_ml);
   assign vol_added   = vol_sum[VOLUME_WIDTH] ? '1 : vol_sum[VOLUME_WIDTH-1:0];
   assign det_cnt_inc = (det_cnt_ff == '1) ? det_cnt_ff : det_cnt_ff + 1'b1;
   assign alm_cnt_inc = (alm_cnt_ff == '1) ? alm_cnt_ff : alm_cnt_ff + 1'b1;
   assign attempt     = det_cnt_inc > interval_ff;

   assign vol_cmp   = CMP_W'(vol_added);
   assign thr1_cmp  = CMP_W'(thr1_ff);
   assign thr2_cmp  = CMP_W'(thr2_ff);
   assign thr3_cmp  = CMP_W'(thr3_ff);
   assign limit_cmp = CMP_W'(limit_ff);

   // one round-robin detector attempt; each threshold window fires once
   always_comb begin
      det_event = EV_NONE;
      det_flags = flags_ff;
      case (slot_ff)
         SLOT_BUTTON: begin
            if (req_button_pushed) det_event = EV_BUTTON;
         end
         SLOT_T1: begin
            if (mode_ff <= MODE_OPEN && !flags_ff[0] &&
                vol_cmp >= thr1_cmp && vol_cmp < thr2_cmp) begin
               det_event = EV_T1;
               det_flags = flags_ff | FLAGS_LVL1;
            end
         end
         SLOT_T2: begin
            if (mode_ff <= MODE_AL1 && !flags_ff[1] &&
                vol_cmp >= thr2_cmp && vol_cmp < thr3_cmp) begin
               det_event = EV_T2;
               det_flags = flags_ff | FLAGS_LVL2;
            end
         end
         SLOT_T3: begin
            if (mode_ff <= MODE_AL2 && !flags_ff[2] &&
                vol_cmp >= thr3_cmp && vol_cmp < limit_cmp) begin
               det_event = EV_T3;
               det_flags = flags_ff | FLAGS_LVL3;
            end
         end
         SLOT_LIMIT: begin
            if (mode_ff <= MODE_AL3 && !flags_ff[3] && vol_cmp >= limit_cmp) begin
               det_event = EV_LIMIT;
               det_flags = flags_ff | FLAGS_LIMIT;
            end
         end
         SLOT_TIMEOUT: begin
            if (mode_ff >= MODE_AL1 && mode_ff <= MODE_LIMIT && alm_cnt_inc > alarm_len_ff)
               det_event = EV_TIMEOUT;
         end
         default: ;
      endcase
   end

   // next state: tick bookkeeping, then the mode machine
   always_comb begin
      mode_in      = mode_ff;
      volume_in    = volume_ff;
      flags_in     = flags_ff;
      slot_in      = slot_ff;
      det_cnt_in   = det_cnt_ff;
      alm_cnt_in   = alm_cnt_ff;
      valve_in     = valve_ff;
      buzzer_in    = buzzer_ff;
      event_in     = event_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (tick_accept) begin
         rsp_valid_in = 1'b1;
         volume_in    = vol_added;
         det_cnt_in   = det_cnt_inc;
         alm_cnt_in   = alm_cnt_inc;
         event_in     = EV_NONE;

         if (attempt) begin
            det_cnt_in = '0;
            event_in   = det_event;
            flags_in   = det_flags;
            slot_in    = (slot_ff >= SLOT_TIMEOUT) ? SLOT_BUTTON
                                                   : slot_type'(slot_ff + 1'b1);
         end

         case (mode_ff)
            MODE_IDLE: begin
               if (event_in == EV_BUTTON) begin
                  valve_in = 1'b1;
                  mode_in  = MODE_OPEN;
               end
            end
            MODE_OPEN: begin
               case (event_in)
                  EV_BUTTON: begin
                     valve_in = 1'b0;
                     mode_in  = MODE_IDLE;
                  end
                  EV_T1: begin
                     buzzer_in  = BUZZ_LVL1;
                     mode_in    = MODE_AL1;
                     alm_cnt_in = '0;
                  end
                  EV_T2: begin
                     buzzer_in  = BUZZ_LVL2;
                     mode_in    = MODE_AL2;
                     alm_cnt_in = '0;
                  end
                  EV_T3: begin
                     buzzer_in  = BUZZ_LVL3;
                     mode_in    = MODE_AL3;
                     alm_cnt_in = '0;
                  end
                  EV_LIMIT: begin
                     buzzer_in  = BUZZ_LVL4;
                     mode_in    = MODE_LIMIT;
                     alm_cnt_in = '0;
                  end
                  default: ;
               endcase
            end
            // escalation keeps the running alarm timer
            MODE_AL1: begin
               if (event_in == EV_TIMEOUT) begin
                  buzzer_in = BUZZ_OFF;
                  mode_in   = MODE_OPEN;
               end else if (event_in == EV_T2) begin
                  buzzer_in = BUZZ_LVL2;
                  mode_in   = MODE_AL2;
               end
            end
            MODE_AL2: begin
               if (event_in == EV_TIMEOUT) begin
                  buzzer_in = BUZZ_OFF;
                  mode_in   = MODE_OPEN;
               end else if (event_in == EV_T3) begin
                  buzzer_in = BUZZ_LVL3;
                  mode_in   = MODE_AL3;
               end
            end
            MODE_AL3: begin
               if (event_in == EV_TIMEOUT) begin
                  buzzer_in = BUZZ_OFF;
                  mode_in   = MODE_OPEN;
               end else if (event_in == EV_LIMIT) begin
                  buzzer_in = BUZZ_LVL4;
                  mode_in   = MODE_LIMIT;
               end
            end
            MODE_LIMIT: begin
               if (event_in == EV_TIMEOUT) begin
                  buzzer_in = BUZZ_OFF;
                  valve_in  = 1'b0;
                  mode_in   = MODE_DONE;
               end
            end
            MODE_DONE: begin
               // button restarts the whole consumption cycle
               if (event_in == EV_BUTTON) begin
                  volume_in = '0;
                  flags_in  = FLAGS_NONE;
                  mode_in   = MODE_IDLE;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         volume_ff    <= '0;
         flags_ff     <= FLAGS_NONE;
         slot_ff      <= SLOT_BUTTON;
         det_cnt_ff   <= '0;
         alm_cnt_ff   <= '0;
         valve_ff     <= 1'b0;
         buzzer_ff    <= BUZZ_OFF;
         event_ff     <= EV_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         volume_ff    <= volume_in;
         flags_ff     <= flags_in;
         slot_ff      <= slot_in;
         det_cnt_ff   <= det_cnt_in;
         alm_cnt_ff   <= alm_cnt_in;
         valve_ff     <= valve_in;
         buzzer_ff    <= buzzer_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ctrl_state      = mode_ff;
   assign rsp_valve_open      = valve_ff;
   assign rsp_buzzer_level    = buzzer_ff;
   assign rsp_event_code      = event_ff;
   assign rsp_total_volume_ml = TOTAL_W'(volume_ff);

   // ---------------- checks ----------------
   // valve is driven open exactly in the open, alarm and limit states
   a_valve_matches_mode: assert property (@(posedge clock) disable iff (reset)
      valve_ff == (mode_ff >= MODE_OPEN && mode_ff <= MODE_LIMIT))
      else $error("valve drive disagrees with mode");

   // buzzer level tracks the alarm state, silent elsewhere
   a_buzzer_matches_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff >= MODE_AL1 && mode_ff <= MODE_LIMIT) ?
         (buzzer_ff == 3'(mode_ff - 3'd1)) : (buzzer_ff == BUZZ_OFF))
      else $error("buzzer level disagrees with mode");

   // used flags only ever fill from the bottom
   a_flags_thermometer: assert property (@(posedge clock) disable iff (reset)
      flags_ff == FLAGS_NONE || flags_ff == FLAGS_LVL1 || flags_ff == FLAGS_LVL2 ||
      flags_ff == FLAGS_LVL3 || flags_ff == FLAGS_LIMIT)
      else $error("used flags not thermometer coded");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_TIMEOUT)
      else $error("detector slot out of range");

   // a held result blocks the next tick
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("tick taken while result stalled");

endmodule
